// ----- rtl/otc_pkg.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator package
// Shared types and constants for the trim search datapath and its stages.
// ----------------------------------------------------------------------------
package otc_pkg;

  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic [31:0] TARGET_RESET = 32'd2356;

  typedef enum logic {
    REG_TARGET_COUNT = 1'b0
  } reg_idx_e;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_MEASURE = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_BINARY   = 4'b0010,
    PH_NEIGHBOR = 4'b0100,
    PH_DONE     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic done_res;
    logic measure_next;
  } res_flags_t;

endpackage

// ----- rtl/oscillator_trim_calibrator.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator
// Successive-approximation trim search with a neighbor probe around the result.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is held in the input register; the search step
// loads its result beat, if any, into the result register. Throughput: one input
// beat per cycle while the result side does not stall, set by the single search step.
// Reset: rst_ni clears the search to idle, empties both stages and loads
// target_count with 2356.
module oscillator_trim_calibrator #(
  parameter int unsigned TRIM_BITS  = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // frame_length
  input  logic [((COUNT_BITS+7)/8)*8-1:0]          s_axis_tdata_i,
  // req_type
  input  logic                                     s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // trim_value
  output logic [((TRIM_BITS+7)/8)*8-1:0]           m_axis_tdata_o,
  // measure_next, done_res
  output logic [1:0]                               m_axis_tuser_o,
  input  logic                                     psel_i,
  input  logic                                     penable_i,
  input  logic                                     pwrite_i,
  input  logic [otc_pkg::APB_ADDR_W-1:0]           paddr_i,
  input  logic [otc_pkg::APB_DATA_W-1:0]           pwdata_i,
  output logic [otc_pkg::APB_DATA_W-1:0]           prdata_o,
  output logic                                     pready_o
);
  import otc_pkg::*;

  localparam int unsigned OutDataW = ((TRIM_BITS+7)/8)*8;

  logic [COUNT_BITS-1:0] target_q;
  logic                  cfg_wr;
  logic                  reg_hit;

  logic                  st_valid;
  logic                  st_req;
  logic [COUNT_BITS-1:0] st_frame;
  logic                  advance;
  logic                  room;
  logic                  res_valid;
  logic [TRIM_BITS-1:0]  res_trim;
  res_flags_t            res_flags;
  logic [TRIM_BITS-1:0]  out_trim;
  res_flags_t            out_flags;

  assign pready_o = 1'b1;
  assign reg_hit  = paddr_i[2] == REG_TARGET_COUNT;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o && reg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET[COUNT_BITS-1:0];
    end else if (cfg_wr) begin
      target_q <= pwdata_i[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (reg_hit) begin
      prdata_o[COUNT_BITS-1:0] = target_q;
    end
  end

  assign advance = st_valid && room;

  otc_in_stage #(
    .COUNT_BITS(COUNT_BITS)
  ) u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .req_type_i    (s_axis_tuser_i),
    .frame_length_i(s_axis_tdata_i[COUNT_BITS-1:0]),
    .advance_i     (advance),
    .stage_valid_o (st_valid),
    .req_type_o    (st_req),
    .frame_length_o(st_frame)
  );

  otc_search #(
    .TRIM_BITS (TRIM_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .req_type_i    (st_req),
    .frame_length_i(st_frame),
    .target_count_i(target_q),
    .res_valid_o   (res_valid),
    .res_trim_o    (res_trim),
    .res_flags_o   (res_flags)
  );

  otc_out_stage #(
    .TRIM_BITS(TRIM_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .trim_i     (res_trim),
    .flags_i    (res_flags),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .trim_o     (out_trim),
    .flags_o    (out_flags)
  );

  always_comb begin
    m_axis_tdata_o                = {OutDataW{1'b0}};
    m_axis_tdata_o[TRIM_BITS-1:0] = out_trim;
  end

  assign m_axis_tuser_o = {out_flags.done_res, out_flags.measure_next};

endmodule

// ----- rtl/otc_in_stage.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator input stage
// Registers one measurement or start beat ahead of the search logic.
// ----------------------------------------------------------------------------
module otc_in_stage #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [COUNT_BITS-1:0] frame_length_i,
  input  logic                  advance_i,
  output logic                  stage_valid_o,
  output logic                  req_type_o,
  output logic [COUNT_BITS-1:0] frame_length_o
);
  import otc_pkg::*;

  logic                  vld_q, vld_d;
  logic                  req_q;
  logic [COUNT_BITS-1:0] frame_q;
  logic                  take;

  assign in_ready_o = !vld_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign vld_d      = take ? 1'b1 : (advance_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q   <= req_type_i;
      frame_q <= frame_length_i;
    end
  end

  assign stage_valid_o  = vld_q;
  assign req_type_o     = req_q;
  assign frame_length_o = frame_q;

endmodule

// ----- rtl/otc_search.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator search core
// Holds the search state and computes one search step per accepted beat.
// ----------------------------------------------------------------------------
module otc_search #(
  parameter int unsigned TRIM_BITS  = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic                      req_type_i,
  input  logic [COUNT_BITS-1:0]     frame_length_i,
  input  logic [COUNT_BITS-1:0]     target_count_i,
  output logic                      res_valid_o,
  output logic [TRIM_BITS-1:0]      res_trim_o,
  output otc_pkg::res_flags_t       res_flags_o
);
  import otc_pkg::*;

  localparam logic [TRIM_BITS-1:0] TrimMsb  = {1'b1, {(TRIM_BITS-1){1'b0}}};
  localparam logic [TRIM_BITS-1:0] TrimMax  = {TRIM_BITS{1'b1}};
  localparam logic [TRIM_BITS-1:0] TrimZero = '0;
  localparam logic [TRIM_BITS-1:0] TrimOne  = {{(TRIM_BITS-1){1'b0}}, 1'b1};

  phase_e                phase_q, phase_d;
  logic [TRIM_BITS-1:0]  base_q, base_d;
  logic [TRIM_BITS-1:0]  step_q, step_d;
  logic [TRIM_BITS-1:0]  probe_q, probe_d;
  logic [TRIM_BITS-1:0]  best_trim_q, best_trim_d;
  logic [COUNT_BITS-1:0] best_dev_q, best_dev_d;

  logic [TRIM_BITS-1:0]  step_half;
  logic [TRIM_BITS-1:0]  base_kept;
  logic [TRIM_BITS-1:0]  top_trim;
  logic [COUNT_BITS-1:0] dev;
  logic                  below;

  assign below     = frame_length_i < target_count_i;
  assign step_half = step_q >> 1;
  assign base_kept = below ? base_q + step_q : base_q;
  assign dev       = below ? target_count_i - frame_length_i
                           : frame_length_i - target_count_i;
  assign top_trim  = (base_q == TrimMax) ? TrimMax : base_q + TrimOne;

  always_comb begin
    phase_d     = phase_q;
    base_d      = base_q;
    step_d      = step_q;
    probe_d     = probe_q;
    best_trim_d = best_trim_q;
    best_dev_d  = best_dev_q;
    res_valid_o = 1'b0;
    res_trim_o  = probe_q;
    res_flags_o = '{done_res: 1'b0, measure_next: 1'b1};
    if (req_type_i == REQ_START) begin
      base_d      = TrimZero;
      step_d      = TrimMsb;
      probe_d     = TrimMsb;
      phase_d     = PH_BINARY;
      res_valid_o = 1'b1;
      res_trim_o  = TrimMsb;
    end else begin
      case (phase_q)
        PH_BINARY: begin
          base_d      = base_kept;
          step_d      = step_half;
          res_valid_o = 1'b1;
          if (step_half != TrimZero) begin
            probe_d = base_kept + step_half;
          end else begin
            best_trim_d = base_kept;
            best_dev_d  = frame_length_i;
            probe_d     = (base_kept == TrimZero) ? TrimZero : base_kept - TrimOne;
            phase_d     = PH_NEIGHBOR;
          end
          res_trim_o = probe_d;
        end
        PH_NEIGHBOR: begin
          if (dev < best_dev_q) begin
            best_dev_d  = dev;
            best_trim_d = probe_q;
          end
          res_valid_o = 1'b1;
          if (probe_q < top_trim) begin
            probe_d    = probe_q + TrimOne;
            res_trim_o = probe_d;
          end else begin
            phase_d     = PH_DONE;
            res_trim_o  = best_trim_d;
            res_flags_o = '{done_res: 1'b1, measure_next: 1'b0};
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      base_q      <= '0;
      step_q      <= TrimMsb;
      probe_q     <= '0;
      best_trim_q <= '0;
      best_dev_q  <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      base_q      <= base_d;
      step_q      <= step_d;
      probe_q     <= probe_d;
      best_trim_q <= best_trim_d;
      best_dev_q  <= best_dev_d;
    end
  end

endmodule

// ----- rtl/otc_out_stage.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator output stage
// Result register that holds a beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module otc_out_stage #(
  parameter int unsigned TRIM_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [TRIM_BITS-1:0] trim_i,
  input  otc_pkg::res_flags_t  flags_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TRIM_BITS-1:0] trim_o,
  output otc_pkg::res_flags_t  flags_o
);
  import otc_pkg::*;

  logic                 vld_q, vld_d;
  logic [TRIM_BITS-1:0] trim_q;
  res_flags_t           flags_q;

  assign room_o = !vld_q || out_ready_i;
  assign vld_d  = load_i ? 1'b1 : (out_ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      trim_q  <= trim_i;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = vld_q;
  assign trim_o      = trim_q;
  assign flags_o     = flags_q;

endmodule

// ----- rtl/otc_checker.sv -----
// ----------------------------------------------------------------------------
// Oscillator trim calibrator checker
// Port-level properties of the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module otc_checker #(
  parameter int unsigned TRIM_BITS  = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [((TRIM_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  input logic [1:0]                           m_axis_tuser_o,
  input logic                                 psel_i,
  input logic                                 penable_i,
  input logic                                 pwrite_i,
  input logic [otc_pkg::APB_ADDR_W-1:0]       paddr_i,
  input logic [otc_pkg::APB_DATA_W-1:0]       pwdata_i,
  input logic [otc_pkg::APB_DATA_W-1:0]       prdata_o,
  input logic                                 pready_o
);
  import otc_pkg::*;

  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result beat shown during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] ^ m_axis_tuser_o[1]))
    else $error("result beat must request a measurement or be final, not both");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && pready_o && (paddr_i[2] == REG_TARGET_COUNT)
      |=> (paddr_i[2] != REG_TARGET_COUNT)
        || (prdata_o[COUNT_BITS-1:0] == $past(pwdata_i[COUNT_BITS-1:0])))
    else $error("target_count readback differs from last write");

endmodule

bind oscillator_trim_calibrator otc_checker #(
  .TRIM_BITS (TRIM_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_otc_checker (.*);

// ----- bench/oscillator_trim_calibrator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator trim calibrator testbench
// Drives start and measurement beats into the trim search and predicts every
// trim it asks for. The run starts with a directed table and then moves to
// random calibrations with modeled oscillator counts, using several target
// counts. Both stream sides idle at random, and the result side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module oscillator_trim_calibrator_tb;
  import otc_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TRIMS_WANTED = 1620;
  localparam int unsigned PHASE_TRIMS  = 130;

  typedef struct packed {
    logic [7:0] trim_value;
    logic       measure_next;
    logic       done_res;
  } trim_res_t;

  typedef struct packed {
    req_type_e   req;
    logic [15:0] frame;
    logic        typed;
    logic        has;
    trim_res_t   res;
  } row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        psel_i          = 1'b0;
  logic        penable_i       = 1'b0;
  logic        pwrite_i        = 1'b0;
  logic [2:0]  paddr_i         = '0;
  logic [31:0] pwdata_i        = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  oscillator_trim_calibrator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  // Search state of the predictor.
  logic [15:0] cal_target   = TARGET_RESET[15:0];
  phase_e      cal_phase    = PH_IDLE;
  logic [7:0]  cal_base     = '0;
  logic [7:0]  cal_bit      = 8'h80;
  logic [8:0]  cal_probe    = '0;
  logic [7:0]  cal_best     = '0;
  logic [16:0] cal_best_dev = '0;

  trim_res_t   expected_trims[$];
  int unsigned trims_issued = 0;
  int unsigned mismatches   = 0;
  int unsigned next_gap     = 0;
  bit          no_idle      = 1'b0;
  bit          hold_off_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void predict_trim(input req_type_e req, input logic [15:0] frame,
                                       output bit has, output trim_res_t res);
    logic [16:0] dev;
    logic [7:0]  top;
    has = 1'b0;
    res = '0;
    if (req == REQ_START) begin
      cal_base  = '0;
      cal_bit   = 8'h80;
      cal_probe = 9'd128;
      cal_phase = PH_BINARY;
      has = 1'b1;
      res = '{cal_probe[7:0], 1'b1, 1'b0};
    end else if (cal_phase == PH_BINARY) begin
      if (frame < cal_target) cal_base = cal_base + cal_bit;
      cal_bit = cal_bit >> 1;
      if (cal_bit != 0) begin
        cal_probe = {1'b0, cal_base + cal_bit};
      end else begin
        cal_best     = cal_base;
        cal_best_dev = {1'b0, frame};
        cal_probe    = (cal_base == 0) ? 9'd0 : {1'b0, cal_base - 8'd1};
        cal_phase    = PH_NEIGHBOR;
      end
      has = 1'b1;
      res = '{cal_probe[7:0], 1'b1, 1'b0};
    end else if (cal_phase == PH_NEIGHBOR) begin
      dev = (frame >= cal_target) ? {1'b0, frame - cal_target} : {1'b0, cal_target - frame};
      if (dev < cal_best_dev) begin
        cal_best_dev = dev;
        cal_best     = cal_probe[7:0];
      end
      top = (cal_base == 8'hFF) ? 8'hFF : cal_base + 8'd1;
      has = 1'b1;
      if (cal_probe < {1'b0, top}) begin
        cal_probe = cal_probe + 9'd1;
        res = '{cal_probe[7:0], 1'b1, 1'b0};
      end else begin
        cal_phase = PH_DONE;
        res = '{cal_best, 1'b0, 1'b1};
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_beat(input req_type_e req, input logic [15:0] frame, input bit typed,
                           input bit typed_has, input trim_res_t typed_res);
    bit        has;
    trim_res_t res;
    if (next_gap != 0) repeat (next_gap) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= frame;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_trim(req, frame, has, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) begin
      expected_trims.push_back(res);
      trims_issued++;
    end
    next_gap = pick_gap();
    if (next_gap != 0) s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    if (next_gap == 0) s_axis_tvalid_i <= 1'b0;
    while (expected_trims.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    paddr_i   <= addr;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    data = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  initial begin : result_sink
    trim_res_t   got;
    trim_res_t   want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got.trim_value   = m_axis_tdata_o;
      got.measure_next = m_axis_tuser_o[0];
      got.done_res     = m_axis_tuser_o[1];
      if (expected_trims.size() == 0) begin
        report_mismatch("unexpected beat, trim_value", got.trim_value, 0);
      end else begin
        want = expected_trims.pop_front();
        if (got.trim_value != want.trim_value)
          report_mismatch("trim_value", got.trim_value, want.trim_value);
        if (got.measure_next != want.measure_next)
          report_mismatch("measure_next", got.measure_next, want.measure_next);
        if (got.done_res != want.done_res)
          report_mismatch("done_res", got.done_res, want.done_res);
      end
    end
  end

  initial begin : stimulus
    row_t        directed_rows [0:25];
    logic [31:0] cfg;
    logic [31:0] rd;
    logic [2:0]  target_addr;
    int unsigned pass_no;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned mode;
    int unsigned n;
    int          center;
    int          slope;
    int          v;

    rst_ni <= 1'b0;
    target_addr = {REG_TARGET_COUNT, 2'b00};
    directed_rows = '{
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
      '{REQ_START,   16'hFFFF, 1'b1, 1'b1, '{8'd128, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd192, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd224, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd240, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd248, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd252, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd254, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd255, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd254, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd255, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0000, 1'b1, 1'b1, '{8'd255, 1'b0, 1'b1}},
      '{REQ_MEASURE, 16'h1234, 1'b1, 1'b0, '{8'd0,   1'b0, 1'b0}},
      '{REQ_START,   16'h0000, 1'b1, 1'b1, '{8'd128, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd64,  1'b1, 1'b0}},
      '{REQ_START,   16'h0000, 1'b1, 1'b1, '{8'd128, 1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd64,  1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd32,  1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd16,  1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd8,   1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd4,   1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd2,   1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd1,   1'b1, 1'b0}},
      '{REQ_MEASURE, 16'hFFFF, 1'b1, 1'b1, '{8'd0,   1'b1, 1'b0}},
      '{REQ_MEASURE, 16'h0934, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}},
      '{REQ_MEASURE, 16'h0935, 1'b0, 1'b0, '{8'd0,   1'b0, 1'b0}}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    next_gap = pick_gap();

    foreach (directed_rows[i])
      send_beat(directed_rows[i].req, directed_rows[i].frame, directed_rows[i].typed,
                directed_rows[i].has, directed_rows[i].res);

    pass_no = 0;
    while (trims_issued < TRIMS_WANTED) begin
      wait_drained();
      case (pass_no)
        0:       cfg = 32'h0000_0000;
        1:       cfg = 32'hFFFF_FFFF;
        2:       cfg = 32'h0000_0934;
        3:       cfg = {16'($urandom_range(0, 65535)), 16'h0001};
        4:       cfg = {16'hA5A5, 16'hFFFE};
        default: cfg = $urandom;
      endcase
      apb_write(target_addr, cfg);
      cal_target = cfg[15:0];
      apb_read(target_addr, rd);
      if (rd[15:0] != cfg[15:0]) report_mismatch("target_count readback", rd[15:0], cfg[15:0]);
      if (pass_no == 3) hold_off_req = 1'b1;
      phase_start = trims_issued;
      while (trims_issued < phase_start + PHASE_TRIMS) begin
        no_idle = (pass_no == 3) || ($urandom_range(0, 6) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          n = $urandom_range(1, 4);
          repeat (n)
            send_beat(($urandom_range(0, 3) == 0) ? REQ_START : REQ_MEASURE,
                      16'($urandom), 1'b0, 1'b0, '0);
        end else if (pick == 1) begin
          send_beat(REQ_START, 16'($urandom), 1'b0, 1'b0, '0);
          n = $urandom_range(0, 7);
          repeat (n) send_beat(REQ_MEASURE, 16'($urandom), 1'b0, 1'b0, '0);
        end else begin
          mode   = $urandom_range(0, 7);
          center = $urandom_range(0, 255);
          slope  = $urandom_range(1, 40);
          send_beat(REQ_START, 16'($urandom), 1'b0, 1'b0, '0);
          while (cal_phase != PH_DONE) begin
            case (mode)
              4:       v = 0;
              5:       v = 65535;
              6:       v = $urandom_range(0, 65535);
              7:       v = int'(cal_target) + $urandom_range(0, 6) - 3;
              default: v = int'(cal_target) + (int'(cal_probe) - center) * slope
                            + $urandom_range(0, 4) - 2;
            endcase
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            send_beat(REQ_MEASURE, 16'(v), 1'b0, 1'b0, '0);
          end
        end
      end
      pass_no++;
    end

    no_idle = 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/otc_pkg.sv
rtl/otc_in_stage.sv
rtl/otc_search.sv
rtl/otc_out_stage.sv
rtl/oscillator_trim_calibrator.sv
rtl/otc_checker.sv
bench/oscillator_trim_calibrator_tb.sv
